/* sv/lcdns_pkg.sv */
package lcdns_pkg;

  // Depth of the request queue between front and back
  localparam int unsigned JOB_DEPTH = 2;

  // Request kinds
  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_DATA   = 2'd2,
    CMD_CURSOR = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam logic [2:0] REG_FUNCTION_SET    = 3'd0;
  localparam logic [2:0] REG_DISPLAY_CONTROL = 3'd1;
  localparam logic [2:0] REG_ENTRY_MODE      = 3'd2;
  localparam logic [2:0] REG_SECOND_ROW_BASE = 3'd3;
  localparam logic [2:0] REG_COMMAND_SETTLE  = 3'd4;
  localparam logic [2:0] REG_DATA_SETTLE     = 3'd5;

  // Register reset values
  localparam logic [7:0] RST_FUNCTION_SET    = 8'h28;
  localparam logic [7:0] RST_DISPLAY_CONTROL = 8'h0C;
  localparam logic [7:0] RST_ENTRY_MODE      = 8'h06;
  localparam logic [6:0] RST_SECOND_ROW_BASE = 7'h40;
  localparam logic [7:0] RST_COMMAND_SETTLE  = 8'd2;
  localparam logic [7:0] RST_DATA_SETTLE     = 8'd1;

  // Bus constants
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
  localparam logic [8:0] POWERUP_MS     = 9'd50;
  localparam logic [8:0] STROBE_MS      = 9'd1;
  localparam logic [8:0] CLEAR_EXTRA_MS = 9'd2;
  localparam logic [8:0] WAKE_FIRST_MS  = 9'd5;
  localparam logic [8:0] WAKE_NEXT_MS   = 9'd1;
  localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
  localparam logic [3:0] MODE_NIBBLE    = 4'h2;

  // Phase numbering of an initialize sequence and a single byte
  localparam logic [4:0] INIT_FIRST_BYTE = 5'd9;
  localparam logic [4:0] INIT_LAST       = 5'd24;
  localparam logic [4:0] BYTE_LAST       = 5'd3;

  typedef struct packed {
    logic [7:0] function_set;
    logic [7:0] display_control;
    logic [7:0] entry_mode;
    logic [6:0] second_row_base;
    logic [7:0] command_settle;
    logic [7:0] data_settle;
  } cfg_t;

  // Classified request as queued for the back end
  typedef struct packed {
    logic       init;
    logic       rs;
    logic [7:0] data;
    logic [7:0] settle;
  } job_t;

  // One bus phase
  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nibble;
    logic [8:0] hold;
    logic       last;
  } phase_t;

endpackage

/* sv/lcdns_cfg.sv */
module lcdns_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output lcdns_pkg::cfg_t     cfg_o
);
  import lcdns_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register index; drop writes beyond the list
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FUNCTION_SET:    cfg_d.function_set    = cfg_data_i;
        REG_DISPLAY_CONTROL: cfg_d.display_control = cfg_data_i;
        REG_ENTRY_MODE:      cfg_d.entry_mode      = cfg_data_i;
        REG_SECOND_ROW_BASE: cfg_d.second_row_base = cfg_data_i[6:0];
        REG_COMMAND_SETTLE:  cfg_d.command_settle  = cfg_data_i;
        REG_DATA_SETTLE:     cfg_d.data_settle     = cfg_data_i;
        default:             cfg_d                 = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.function_set    <= RST_FUNCTION_SET;
      cfg_q.display_control <= RST_DISPLAY_CONTROL;
      cfg_q.entry_mode      <= RST_ENTRY_MODE;
      cfg_q.second_row_base <= RST_SECOND_ROW_BASE;
      cfg_q.command_settle  <= RST_COMMAND_SETTLE;
      cfg_q.data_settle     <= RST_DATA_SETTLE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* sv/lcdns_front.sv */
module lcdns_front #(
  parameter int unsigned Depth = lcdns_pkg::JOB_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          value_i,
  input  logic [5:0]          col_i,
  input  logic                row_i,
  input  lcdns_pkg::cfg_t     cfg_i,
  output logic                job_valid_o,
  output lcdns_pkg::job_t     job_o,
  input  logic                job_pop_i
);
  import lcdns_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_e            cmd;
  logic [6:0]      addr;
  job_t            job_in;
  logic            push_ok;
  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // Classify the request word and resolve the byte it sends
  always_comb begin
    cmd  = cmd_e'(cmd_i);
    addr = row_i ? (cfg_i.second_row_base + {1'b0, col_i}) : {1'b0, col_i};
    job_in.init   = (cmd == CMD_INIT);
    job_in.rs     = (cmd == CMD_DATA);
    job_in.settle = (cmd == CMD_DATA) ? cfg_i.data_settle : cfg_i.command_settle;
    unique case (cmd)
      CMD_CURSOR: job_in.data = CMD_SET_ADDR | {1'b0, addr};
      CMD_INIT,
      CMD_BYTE,
      CMD_DATA:   job_in.data = value_i;
    endcase
  end

  assign full_o      = (count_q == CntW'(Depth));
  assign push_ok     = push_i && !full_o;
  assign job_valid_o = (count_q != '0);
  assign job_o       = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (job_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_ok, job_pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified word
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= job_in;
    end
  end

endmodule

/* sv/lcdns_back.sv */
module lcdns_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcdns_pkg::cfg_t     cfg_i,
  input  logic                job_valid_i,
  input  lcdns_pkg::job_t     job_i,
  output logic                job_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output lcdns_pkg::phase_t   phase_o
);
  import lcdns_pkg::*;

  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q;
  phase_t     out_q;
  phase_t     phase;
  logic       advance;
  logic       fire;
  logic [4:0] wake_idx;
  logic [4:0] byte_idx;
  logic [1:0] pair;
  logic [1:0] sub;
  logic [1:0] bsel;
  logic [7:0] cur_byte;
  logic [8:0] settle;
  logic       is_clear;

  assign advance = !out_valid_q || pop_i;
  assign fire    = job_valid_i && advance;
  assign empty_o = !out_valid_q;
  assign phase_o = out_q;

  // Work out the phase at the current position of the head word
  always_comb begin
    wake_idx = cnt_q - 5'd1;
    byte_idx = cnt_q - INIT_FIRST_BYTE;
    pair     = wake_idx[2:1];
    bsel     = byte_idx[3:2];
    sub      = job_i.init ? byte_idx[1:0] : cnt_q[1:0];
    is_clear = job_i.init && (bsel == 2'd3);
    unique case (bsel)
      2'd0: cur_byte = cfg_i.function_set;
      2'd1: cur_byte = cfg_i.display_control;
      2'd2: cur_byte = cfg_i.entry_mode;
      2'd3: cur_byte = CMD_CLEAR;
    endcase
    if (!job_i.init) begin
      cur_byte = job_i.data;
    end
    settle = {1'b0, job_i.settle} + STROBE_MS + (is_clear ? CLEAR_EXTRA_MS : 9'd0);

    phase.rs   = job_i.rs;
    phase.last = job_i.init ? (cnt_q == INIT_LAST) : (cnt_q == BYTE_LAST);
    priority if (job_i.init && cnt_q == 5'd0) begin
      // power-up wait, all lines low
      phase.en     = 1'b0;
      phase.nibble = 4'h0;
      phase.hold   = POWERUP_MS;
    end else if (job_i.init && cnt_q < INIT_FIRST_BYTE) begin
      // wake-up nibbles, then the 4-bit mode nibble
      phase.en     = !wake_idx[0];
      phase.nibble = (pair == 2'd3) ? MODE_NIBBLE : WAKE_NIBBLE;
      if (!wake_idx[0]) begin
        phase.hold = STROBE_MS;
      end else begin
        phase.hold = STROBE_MS + ((pair == 2'd0) ? WAKE_FIRST_MS : WAKE_NEXT_MS);
      end
    end else begin
      // byte phases: high nibble, then low nibble
      phase.en     = !sub[0];
      phase.nibble = sub[1] ? cur_byte[3:0] : cur_byte[7:4];
      phase.hold   = (sub == 2'd3) ? settle : STROBE_MS;
    end
  end

  // Step through the phases; drop the head word after its final phase
  assign job_pop_o = fire && phase.last;
  always_comb begin
    cnt_d = cnt_q;
    if (fire) begin
      cnt_d = phase.last ? 5'd0 : cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (advance) begin
        out_valid_q <= job_valid_i;
      end
    end
  end

  // Hold the phase for the consumer
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= phase;
    end
  end

endmodule

/* sv/char_lcd_nibble_write_sequencer.sv */
// Channel   | Handshake                         | Word
// ----------+-----------------------------------+-------------------------------------
// request   | push_i / full_o                   | cmd_i, value_i, col_i, row_i
// phase     | pop_i / empty_o                   | reg_select_o, enable_o, nibble_o,
//           |                                   | hold_ms_o, last_o
// config    | cfg_valid_i / cfg_ready_o         | cfg_index_i, cfg_data_i
//
// A byte request yields 4 phase words, initialize yields 25, one per cycle while
// pop_i keeps up; the back end's phase counter sets that rate.
// A request is stored in the request queue first; its first phase is then registered in
// the back end's phase output, where it can be popped once empty_o is low.
// The request queue holds JobDepth words, so requests are taken while earlier
// ones are still being expanded. Reset empties the queue and the phase output
// and restores the register defaults; no clearing pass is needed.
module char_lcd_nibble_write_sequencer #(
  parameter int unsigned JobDepth = lcdns_pkg::JOB_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] value_i,
  input  logic [5:0] col_i,
  input  logic       row_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic       reg_select_o,
  output logic       enable_o,
  output logic [3:0] nibble_o,
  output logic [8:0] hold_ms_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import lcdns_pkg::*;

  cfg_t   cfg;
  job_t   job;
  logic   job_valid;
  logic   job_pop;
  phase_t phase;

  lcdns_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lcdns_front #(
    .Depth(JobDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .cfg_i      (cfg),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_pop_i  (job_pop)
  );

  lcdns_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .job_valid_i(job_valid),
    .job_i      (job),
    .job_pop_o  (job_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .phase_o    (phase)
  );

  assign reg_select_o = phase.rs;
  assign enable_o     = phase.en;
  assign nibble_o     = phase.nibble;
  assign hold_ms_o    = phase.hold;
  assign last_o       = phase.last;

  // A full queue always has a word at its head
  a_full_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> job_valid)
    else $error("queue full without a head word");

  // The head word is dropped only while the queue holds one
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid)
    else $error("head word dropped from empty queue");

  // Every request ends on an enable-low phase
  a_last_enable_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && last_o) |-> !enable_o)
    else $error("final phase with enable high");

  // No phase has a zero hold time
  a_hold_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (hold_ms_o != 9'd0))
    else $error("phase with zero hold");

endmodule

/* verif/tb_top.sv */
module tb_top;
  import lcdns_pkg::*;

  // Unused register slots, writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned MAX_WAIT      = 10;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned RANDOM_ROUNDS = 5;
  localparam int unsigned ROUND_ITEMS   = 44;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] value;
    logic [5:0] col;
    logic       row;
  } lcd_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push_i = 1'b0;
  logic [1:0] cmd_i = 2'd0;
  logic [7:0] value_i = 8'd0;
  logic [5:0] col_i = 6'd0;
  logic       row_i = 1'b0;
  logic       pop_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = 3'd0;
  logic [7:0] cfg_data_i = 8'd0;
  logic       full_o;
  logic       empty_o;
  logic       reg_select_o;
  logic       enable_o;
  logic [3:0] nibble_o;
  logic [8:0] hold_ms_o;
  logic       last_o;
  logic       cfg_ready_o;

  // Requests waiting to be pushed, bus phases waiting to come out
  lcd_req_t    req_q[$];
  phase_t      phase_q[$];
  phase_t      want_word;
  cfg_t        lcd_cfg;

  int unsigned errors = 0;
  int unsigned reqs_sent = 0;
  int unsigned inits_sent = 0;
  int unsigned words_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned pop_gap = 0;
  int unsigned pop_calm = 0;

  char_lcd_nibble_write_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .reg_select_o (reg_select_o),
    .enable_o     (enable_o),
    .nibble_o     (nibble_o),
    .hold_ms_o    (hold_ms_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  // Draw the wait before the next word; now and then run a stretch with no waits
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) calm = $urandom_range(8, 30);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic add_phase(input logic rs, input logic en, input logic [3:0] nib,
                           input logic [8:0] hold);
    phase_t p;
    p.rs     = rs;
    p.en     = en;
    p.nibble = nib;
    p.hold   = hold;
    p.last   = 1'b0;
    phase_q.push_back(p);
  endtask

  // Strobe one nibble: enable high, then enable low carrying the extra wait
  task automatic add_nibble(input logic rs, input logic [3:0] nib, input logic [8:0] extra);
    add_phase(rs, 1'b1, nib, STROBE_MS);
    add_phase(rs, 1'b0, nib, STROBE_MS + extra);
  endtask

  task automatic add_byte(input logic rs, input logic [7:0] b, input logic [8:0] extra);
    add_nibble(rs, b[7:4], 9'd0);
    add_nibble(rs, b[3:0], extra);
  endtask

  // Work out the bus phases one request turns into
  task automatic expand_request(input lcd_req_t req);
    logic [8:0] cmd_settle;
    logic [6:0] addr;
    phase_t     tail;
    cmd_settle = {1'b0, lcd_cfg.command_settle};
    case (req.cmd)
      CMD_INIT: begin
        add_phase(1'b0, 1'b0, 4'h0, POWERUP_MS);
        add_nibble(1'b0, WAKE_NIBBLE, WAKE_FIRST_MS);
        add_nibble(1'b0, WAKE_NIBBLE, WAKE_NEXT_MS);
        add_nibble(1'b0, WAKE_NIBBLE, WAKE_NEXT_MS);
        add_nibble(1'b0, MODE_NIBBLE, WAKE_NEXT_MS);
        add_byte(1'b0, lcd_cfg.function_set, cmd_settle);
        add_byte(1'b0, lcd_cfg.display_control, cmd_settle);
        add_byte(1'b0, lcd_cfg.entry_mode, cmd_settle);
        add_byte(1'b0, CMD_CLEAR, cmd_settle + CLEAR_EXTRA_MS);
      end
      CMD_BYTE: add_byte(1'b0, req.value, cmd_settle);
      CMD_DATA: add_byte(1'b1, req.value, {1'b0, lcd_cfg.data_settle});
      default: begin
        addr = req.row ? lcd_cfg.second_row_base + {1'b0, req.col} : {1'b0, req.col};
        add_byte(1'b0, CMD_SET_ADDR | {1'b0, addr}, cmd_settle);
      end
    endcase
    tail = phase_q.pop_back();
    tail.last = 1'b1;
    phase_q.push_back(tail);
  endtask

  task automatic queue_request(input cmd_e c, input logic [7:0] v, input logic [5:0] col,
                               input logic row);
    lcd_req_t r;
    r.cmd   = c;
    r.value = v;
    r.col   = col;
    r.row   = row;
    req_q.push_back(r);
  endtask

  // Write one register through the config channel and track it
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    case (idx)
      REG_FUNCTION_SET:    lcd_cfg.function_set    = data;
      REG_DISPLAY_CONTROL: lcd_cfg.display_control = data;
      REG_ENTRY_MODE:      lcd_cfg.entry_mode      = data;
      REG_SECOND_ROW_BASE: lcd_cfg.second_row_base = data[6:0];
      REG_COMMAND_SETTLE:  lcd_cfg.command_settle  = data;
      REG_DATA_SETTLE:     lcd_cfg.data_settle     = data;
      default: ;
    endcase
  endtask

  // Hold until every request is pushed and every phase word has come back
  task automatic wait_drained;
    while (req_q.size() != 0 || push_i || phase_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (push_i && !full_o) begin
        if (req_q[0].cmd == CMD_INIT) inits_sent++;
        expand_request(req_q.pop_front());
        reqs_sent++;
        send_gap = draw_wait(send_calm);
      end else if (!push_i && send_gap > 0) begin
        send_gap--;
      end
      if (!(push_i && full_o)) begin
        if (send_gap == 0 && req_q.size() > 0) begin
          push_i  <= 1'b1;
          cmd_i   <= req_q[0].cmd;
          value_i <= req_q[0].value;
          col_i   <= req_q[0].col;
          row_i   <= req_q[0].row;
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // Phase monitor: pop with random stalls and check each word
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
      pop_gap = 0;
    end else begin
      if (pop_i && !empty_o) begin
        words_seen++;
        if (phase_q.size() == 0) begin
          flag_error($sformatf("unexpected word %0d: rs %0d en %0d nibble %h hold %0d last %0d",
                               words_seen, reg_select_o, enable_o, nibble_o, hold_ms_o,
                               last_o));
        end else begin
          want_word = phase_q.pop_front();
          if (reg_select_o !== want_word.rs)
            flag_error($sformatf("word %0d reg_select: expected %0d, got %0d",
                                 words_seen, want_word.rs, reg_select_o));
          if (enable_o !== want_word.en)
            flag_error($sformatf("word %0d enable: expected %0d, got %0d",
                                 words_seen, want_word.en, enable_o));
          if (nibble_o !== want_word.nibble)
            flag_error($sformatf("word %0d nibble: expected %h, got %h",
                                 words_seen, want_word.nibble, nibble_o));
          if (hold_ms_o !== want_word.hold)
            flag_error($sformatf("word %0d hold_ms: expected %0d, got %0d",
                                 words_seen, want_word.hold, hold_ms_o));
          if (last_o !== want_word.last)
            flag_error($sformatf("word %0d last: expected %0d, got %0d",
                                 words_seen, want_word.last, last_o));
        end
        pop_gap = draw_wait(pop_calm);
      end else if (!pop_i && pop_gap > 0) begin
        pop_gap--;
      end
      pop_i <= (pop_gap == 0);
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    lcd_req_t    r;
    int unsigned pick;
    logic [7:0]  data;
    lcd_cfg.function_set    = RST_FUNCTION_SET;
    lcd_cfg.display_control = RST_DISPLAY_CONTROL;
    lcd_cfg.entry_mode      = RST_ENTRY_MODE;
    lcd_cfg.second_row_base = RST_SECOND_ROW_BASE;
    lcd_cfg.command_settle  = RST_COMMAND_SETTLE;
    lcd_cfg.data_settle     = RST_DATA_SETTLE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: every request kind, field extremes, cursor corners
    queue_request(CMD_INIT, 8'h00, 6'd0, 1'b0);
    queue_request(CMD_BYTE, 8'h00, 6'd0, 1'b0);
    queue_request(CMD_BYTE, 8'hFF, 6'd63, 1'b1);
    queue_request(CMD_DATA, 8'h00, 6'd0, 1'b0);
    queue_request(CMD_DATA, 8'hFF, 6'd63, 1'b1);
    queue_request(CMD_DATA, 8'hA5, 6'd21, 1'b0);
    queue_request(CMD_CURSOR, 8'h00, 6'd0, 1'b0);
    queue_request(CMD_CURSOR, 8'hFF, 6'd63, 1'b0);
    queue_request(CMD_CURSOR, 8'h5A, 6'd0, 1'b1);
    queue_request(CMD_CURSOR, 8'h00, 6'd63, 1'b1);
    queue_request(CMD_INIT, 8'hFF, 6'd63, 1'b1);
    wait_drained();

    // All registers at their top, spare slots written too (must be dropped)
    write_reg(REG_FUNCTION_SET, 8'hFF);
    write_reg(REG_DISPLAY_CONTROL, 8'hFF);
    write_reg(REG_ENTRY_MODE, 8'hFF);
    write_reg(REG_SECOND_ROW_BASE, 8'hFF);
    write_reg(REG_COMMAND_SETTLE, 8'hFF);
    write_reg(REG_DATA_SETTLE, 8'hFF);
    write_reg(REG_SPARE_LO, 8'h00);
    write_reg(REG_SPARE_HI, 8'h55);
    queue_request(CMD_INIT, 8'h00, 6'd0, 1'b0);
    queue_request(CMD_CURSOR, 8'h00, 6'd63, 1'b1);
    queue_request(CMD_CURSOR, 8'h00, 6'd1, 1'b1);
    queue_request(CMD_BYTE, 8'hC3, 6'd0, 1'b0);
    queue_request(CMD_DATA, 8'h3C, 6'd0, 1'b0);
    wait_drained();

    // All registers at zero
    write_reg(REG_FUNCTION_SET, 8'h00);
    write_reg(REG_DISPLAY_CONTROL, 8'h00);
    write_reg(REG_ENTRY_MODE, 8'h00);
    write_reg(REG_SECOND_ROW_BASE, 8'h00);
    write_reg(REG_COMMAND_SETTLE, 8'h00);
    write_reg(REG_DATA_SETTLE, 8'h00);
    queue_request(CMD_INIT, 8'h00, 6'd0, 1'b0);
    queue_request(CMD_CURSOR, 8'h00, 6'd5, 1'b1);
    queue_request(CMD_BYTE, 8'h81, 6'd0, 1'b0);
    queue_request(CMD_DATA, 8'h7E, 6'd0, 1'b0);
    wait_drained();

    // Random rounds, each under a fresh register setting
    for (int rnd = 0; rnd < RANDOM_ROUNDS; rnd++) begin
      for (int idx = REG_FUNCTION_SET; idx <= REG_DATA_SETTLE; idx++) begin
        pick = $urandom_range(0, 3);
        data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        write_reg(3'(idx), data);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 8'($urandom));
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        pick    = $urandom_range(0, 9);
        r.cmd   = (pick == 0) ? CMD_INIT : cmd_e'($urandom_range(1, 3));
        r.value = 8'($urandom);
        r.col   = 6'($urandom);
        r.row   = 1'($urandom);
        req_q.push_back(r);
      end
      wait_drained();
    end

    $display("Sent %0d requests (%0d initialize) under %0d register writes;",
             reqs_sent, inits_sent, reg_writes);
    $display("checked %0d phase words with random push gaps and pop stalls.", words_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
